// ===== rtl/qte_pkg.sv =====
// Shared types, widths and the arctangent table for the quaternion to Euler angle block.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package qte_pkg;

  // Default number of CORDIC micro-rotations.
  localparam int QTE_ITER_DEFAULT = 16;
  // Size of the arctangent table index range; the function gives entries for indices 0 to 22 and zero above.
  localparam int QTE_TAB_LEN = 24;

  // Width of the atan2 operands leaving the front end.
  localparam int QTE_OPW = 34;
  // Width of the CORDIC x/y datapath (operands scaled by 256 plus gain headroom).
  localparam int QTE_CW = 43;
  // Width of the angle accumulator in 1/65536 degree units.
  localparam int QTE_ZW = 26;
  // Width of the angle after rounding to 1/64 degree, before saturation.
  localparam int QTE_RW = QTE_ZW - 10;

  // 180 degrees in accumulator units.
  localparam logic signed [QTE_ZW-1:0] QTE_DEG180 = QTE_ZW'(180 * 65536);

  // Output limits in 1/64 degree.
  localparam int QTE_OUT180 = 11520;
  localparam int QTE_OUT90  = 5760;

  // Operands of the two atan2 channels plus the clamped asin argument.
  // The asin argument spans [-2^30, 2^30] and so needs 32 signed bits.
  typedef struct packed {
    logic signed [QTE_OPW-1:0] roll_y;
    logic signed [QTE_OPW-1:0] roll_x;
    logic signed [QTE_OPW-1:0] yaw_y;
    logic signed [QTE_OPW-1:0] yaw_x;
    logic signed [31:0]        sin_p;
  } qte_side_t;

  // Front end result: side operands and the radicand 2^60 - s^2.
  typedef struct packed {
    qte_side_t   side;
    logic [60:0] rad;
  } qte_front_t;

  // atan(2^-i) in degrees, 1/65536 degree units, rounded to nearest.
  function automatic logic signed [QTE_ZW-1:0] qte_atan_deg(input int unsigned i);
    logic signed [QTE_ZW-1:0] v;
    unique case (i)
      0:  v = QTE_ZW'(2949120);
      1:  v = QTE_ZW'(1740967);
      2:  v = QTE_ZW'(919879);
      3:  v = QTE_ZW'(466945);
      4:  v = QTE_ZW'(234379);
      5:  v = QTE_ZW'(117304);
      6:  v = QTE_ZW'(58666);
      7:  v = QTE_ZW'(29335);
      8:  v = QTE_ZW'(14668);
      9:  v = QTE_ZW'(7334);
      10: v = QTE_ZW'(3667);
      11: v = QTE_ZW'(1833);
      12: v = QTE_ZW'(917);
      13: v = QTE_ZW'(458);
      14: v = QTE_ZW'(229);
      15: v = QTE_ZW'(115);
      16: v = QTE_ZW'(57);
      17: v = QTE_ZW'(29);
      18: v = QTE_ZW'(14);
      19: v = QTE_ZW'(7);
      20: v = QTE_ZW'(4);
      21: v = QTE_ZW'(2);
      22: v = QTE_ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/qte_front.sv =====
// Front end: component products, atan2 operand sums, asin clamp and the sqrt radicand.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [15:0]  in_w,
  input  logic signed [15:0]  in_x,
  input  logic signed [15:0]  in_y,
  input  logic signed [15:0]  in_z,
  output logic                out_valid,
  output qte_pkg::qte_front_t out_data
);
  import qte_pkg::*;

  // Stage 1: products.
  logic signed [31:0] ww_r, xx_r, yy_r, zz_r, yz_r, xw_r, xy_r, zw_r, xz_r, yw_r;
  logic               v1_r;
  // Stage 2: sums and clamp.
  qte_side_t          side2_r, side2_nxt;
  logic               v2_r;
  // Stage 3: square of the asin argument.
  qte_side_t          side3_r;
  logic [60:0]        sq3_r;
  logic signed [61:0] sq_full;
  logic               v3_r;
  // Stage 4: radicand.
  qte_front_t         out_r;
  logic               v4_r;

  logic signed [QTE_OPW-1:0] t_ry, t_yy, t_sd, t_s;

  always_comb begin
    t_ry = QTE_OPW'(yz_r) + QTE_OPW'(xw_r);
    side2_nxt.roll_y = t_ry <<< 1;
    side2_nxt.roll_x = -QTE_OPW'(xx_r) - QTE_OPW'(yy_r) + QTE_OPW'(zz_r) + QTE_OPW'(ww_r);
    t_yy = QTE_OPW'(xy_r) + QTE_OPW'(zw_r);
    side2_nxt.yaw_y = t_yy <<< 1;
    side2_nxt.yaw_x = QTE_OPW'(xx_r) - QTE_OPW'(yy_r) - QTE_OPW'(zz_r) + QTE_OPW'(ww_r);
    t_sd = QTE_OPW'(xz_r) - QTE_OPW'(yw_r);
    t_s  = -(t_sd <<< 1);
    // Clamp the asin argument to [-1, 1] in Q.30.
    if (t_s > QTE_OPW'(64'sd1073741824)) begin
      side2_nxt.sin_p = 32'sd1073741824;
    end else if (t_s < -QTE_OPW'(64'sd1073741824)) begin
      side2_nxt.sin_p = -32'sd1073741824;
    end else begin
      side2_nxt.sin_p = t_s[31:0];
    end
  end

  assign sq_full = side2_r.sin_p * side2_r.sin_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
    ww_r <= in_w * in_w;
    xx_r <= in_x * in_x;
    yy_r <= in_y * in_y;
    zz_r <= in_z * in_z;
    yz_r <= in_y * in_z;
    xw_r <= in_x * in_w;
    xy_r <= in_x * in_y;
    zw_r <= in_z * in_w;
    xz_r <= in_x * in_z;
    yw_r <= in_y * in_w;
    side2_r <= side2_nxt;
    side3_r <= side2_r;
    sq3_r   <= sq_full[60:0];
    out_r.side <= side3_r;
    out_r.rad  <= (61'd1 << 60) - sq3_r;
  end

  assign out_valid = v4_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/qte_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, carrying side operands.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_isqrt (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  qte_pkg::qte_front_t in_data,
  output logic                out_valid,
  output logic [30:0]         out_root,
  output qte_pkg::qte_side_t  out_side
);
  import qte_pkg::*;

  localparam int STEPS = 31;

  logic [61:0] rem_r  [0:STEPS];
  logic [61:0] res_r  [0:STEPS];
  qte_side_t   side_r [0:STEPS];
  logic        vld_r  [0:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    rem_r[0]  <= {1'b0, in_data.rad};
    res_r[0]  <= '0;
    side_r[0] <= in_data.side;
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [61:0] BIT = 62'd1 << (60 - 2 * k);
    logic [61:0] trial;
    logic [61:0] rem_nxt, res_nxt;

    always_comb begin
      trial = res_r[k] + BIT;
      if (rem_r[k] >= trial) begin
        rem_nxt = rem_r[k] - trial;
        res_nxt = (res_r[k] >> 1) + BIT;
      end else begin
        rem_nxt = rem_r[k];
        res_nxt = res_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      rem_r[k+1]  <= rem_nxt;
      res_r[k+1]  <= res_nxt;
      side_r[k+1] <= side_r[k];
    end
  end

  assign out_valid = vld_r[STEPS];
  assign out_root  = res_r[STEPS][30:0];
  assign out_side  = side_r[STEPS];

endmodule

// ===== rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC giving atan2(y, x) in 1/64 degree, saturated to +-LIM.
// Depends on qte_pkg.
`timescale 1ns / 1ps

module qte_cordic #(
  parameter int ITER  = qte_pkg::QTE_ITER_DEFAULT,
  parameter int LIM   = qte_pkg::QTE_OUT180,
  parameter int OUT_W = 15
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic signed [qte_pkg::QTE_OPW-1:0]   in_y,
  input  logic signed [qte_pkg::QTE_OPW-1:0]   in_x,
  output logic                                 out_valid,
  output logic signed [OUT_W-1:0]              out_angle
);
  import qte_pkg::*;

  localparam logic signed [QTE_RW-1:0] LIM_P = QTE_RW'(LIM);
  localparam logic signed [QTE_RW-1:0] LIM_N = -QTE_RW'(LIM);

  logic signed [QTE_CW-1:0] x_r [0:ITER];
  logic signed [QTE_CW-1:0] y_r [0:ITER];
  logic signed [QTE_ZW-1:0] z_r [0:ITER];
  logic                     zero_r [0:ITER];
  logic                     vld_r  [0:ITER];

  // Pre-rotation: scale by 256 and fold the left half plane onto the right.
  logic signed [QTE_CW-1:0] xe, ye;
  assign xe = {{(QTE_CW-QTE_OPW-8){in_x[QTE_OPW-1]}}, in_x, 8'd0};
  assign ye = {{(QTE_CW-QTE_OPW-8){in_y[QTE_OPW-1]}}, in_y, 8'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
    zero_r[0] <= (in_x == '0) && (in_y == '0);
    if (xe < 0) begin
      x_r[0] <= -xe;
      y_r[0] <= -ye;
      z_r[0] <= (ye >= 0) ? QTE_DEG180 : -QTE_DEG180;
    end else begin
      x_r[0] <= xe;
      y_r[0] <= ye;
      z_r[0] <= '0;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_rot
    localparam logic signed [QTE_ZW-1:0] ATAN = qte_atan_deg(i);
    logic signed [QTE_CW-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else begin
        vld_r[i+1] <= vld_r[i];
      end
      zero_r[i+1] <= zero_r[i];
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + ATAN;
      end else begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - ATAN;
      end
    end
  end

  // Round to 1/64 degree and saturate.
  logic signed [QTE_ZW-1:0] z_rnd;
  logic signed [QTE_RW-1:0] r_q, r_sat;
  logic signed [OUT_W-1:0]  angle_r;
  logic                     out_vld_r;

  always_comb begin
    z_rnd = z_r[ITER] + QTE_ZW'(512);
    r_q   = z_rnd[QTE_ZW-1:10];
    if (zero_r[ITER]) begin
      r_sat = '0;
    end else if (r_q > LIM_P) begin
      r_sat = LIM_P;
    end else if (r_q < LIM_N) begin
      r_sat = LIM_N;
    end else begin
      r_sat = r_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r[ITER];
    end
    angle_r <= r_sat[OUT_W-1:0];
  end

  assign out_valid = out_vld_r;
  assign out_angle = angle_r;

endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
// Top level of the quaternion to Euler angle converter.
// Depends on qte_pkg, qte_front, qte_isqrt and qte_cordic.
`timescale 1ns / 1ps

// This block takes one orientation quaternion (Q1.15 components) per transaction and
// returns roll, pitch and yaw in 1/64 degree steps. It is a fully pipelined datapath
// that accepts a new transaction on every clock cycle; busy is always low. Each result
// appears on the out_ ports for exactly one cycle, marked by out_valid. The pipeline
// consists of four front-end stages (products, sums, square, radicand), a 32-stage
// square root for the pitch cosine, and the CORDIC pipelines with one stage per
// micro-rotation plus an entry and a rounding stage. The receiver cannot stall the
// block, so it must take every result in the cycle it is offered. Non-unit
// quaternions are used as given; angles saturate at +-180 (roll, yaw) and +-90
// (pitch) degrees, and atan2 of zero over zero returns zero.

module quaternion_to_euler_angles #(
  parameter int ANGLE_ITERATIONS = qte_pkg::QTE_ITER_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  output logic signed [14:0] out_roll_angle,
  output logic signed [13:0] out_pitch_angle,
  output logic signed [14:0] out_yaw_angle
);
  import qte_pkg::*;

  // The pipeline never stops, so a transaction is always accepted.
  assign busy = 1'b0;

  logic       front_valid;
  qte_front_t front_data;

  // Products, operand sums, the clamped asin argument and its radicand 2^60 - s^2.
  qte_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start),
    .in_w      (in_quat_w),
    .in_x      (in_quat_x),
    .in_y      (in_quat_y),
    .in_z      (in_quat_z),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  logic        sq_valid;
  logic [30:0] sq_root;
  qte_side_t   sq_side;

  // The square root gives the pitch cosine; roll and yaw operands ride along
  // so that all three angles leave the CORDICs in the same cycle.
  qte_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  logic signed [QTE_OPW-1:0] pitch_y, pitch_x;
  assign pitch_y = {{(QTE_OPW-32){sq_side.sin_p[31]}}, sq_side.sin_p};
  assign pitch_x = {{(QTE_OPW-31){1'b0}}, sq_root};

  logic roll_valid, pitch_valid, yaw_valid;

  qte_cordic #(
    .ITER  (ANGLE_ITERATIONS),
    .LIM   (QTE_OUT180),
    .OUT_W (15)
  ) u_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_y      (sq_side.roll_y),
    .in_x      (sq_side.roll_x),
    .out_valid (roll_valid),
    .out_angle (out_roll_angle)
  );

  // Pitch is asin(s) computed as atan2(s, sqrt(1 - s^2)).
  qte_cordic #(
    .ITER  (ANGLE_ITERATIONS),
    .LIM   (QTE_OUT90),
    .OUT_W (14)
  ) u_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_y      (pitch_y),
    .in_x      (pitch_x),
    .out_valid (pitch_valid),
    .out_angle (out_pitch_angle)
  );

  qte_cordic #(
    .ITER  (ANGLE_ITERATIONS),
    .LIM   (QTE_OUT180),
    .OUT_W (15)
  ) u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_y      (sq_side.yaw_y),
    .in_x      (sq_side.yaw_x),
    .out_valid (yaw_valid),
    .out_angle (out_yaw_angle)
  );

  // The three channels run in lockstep; their valid bits always agree.
  assign out_valid = roll_valid & pitch_valid & yaw_valid;

endmodule
